[design/tsp_pkg.sv]
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants for the exhaustive tour search
// Field widths, command codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int CITY_W = 4;
  localparam int STEP_W = 4;
  localparam int DIST_W = 16;
  localparam int LEN_W  = 20;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] CITY_COUNT_RESET = 4'd2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SOLVE = 1'b1
  } command_t;

  // Register index taken from paddr[2] (registers sit at 4*i).
  localparam logic REG_CITY_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD,
    ST_CLOSE,
    ST_EMIT
  } state_t;

endpackage

[design/tsp_in_if.sv]
// ----------------------------------------------------------------------------
// tsp_in_if: command channel of the tour search
// Carries distance writes and solve requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsp_in_if;
  import tsp_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [CITY_W-1:0] from_city;
  logic [CITY_W-1:0] to_city;
  logic [DIST_W-1:0] distance;

  modport source (output valid, command, from_city, to_city, distance, input ready);
  modport sink   (input valid, command, from_city, to_city, distance, output ready);
endinterface

[design/tsp_out_if.sv]
// ----------------------------------------------------------------------------
// tsp_out_if: result channel of the tour search
// Carries one city of the best tour per transfer.
// ----------------------------------------------------------------------------
interface tsp_out_if;
  import tsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step;
  logic [CITY_W-1:0] city;
  logic [LEN_W-1:0]  tour_length;
  logic              last;

  modport source (output valid, step, city, tour_length, last, input ready);
  modport sink   (input valid, step, city, tour_length, last, output ready);
endinterface

[design/tsp_exhaustive_search.sv]
// ----------------------------------------------------------------------------
// tsp_exhaustive_search: brute-force shortest closed tour
// Loads an asymmetric distance matrix, enumerates every tour from city 0 in
// lexicographic depth-first order and streams out the shortest one.
// ----------------------------------------------------------------------------
//
//   channel | dir | transfer contents
//   --------+-----+------------------------------------------------------
//   cmd     | in  | command, from_city, to_city, distance
//   res     | out | step, city, tour_length, last (n+1 transfers a solve)
//   apb     | cfg | city_count at byte address 0
//
// A solve runs a depth-first search with one shared adder and compare: it
// spends an ST_SCAN state on each candidate city tested at a position (the
// end of the candidate list included), an ST_ADD state on each extension
// (distance lookup and add) and an ST_CLOSE state on each closed tour, then
// streams the n+1 results, held by any result stalls. The single read port
// of the distance memory sets that pace. Reset is synchronous and clears
// the sequencer and city_count; the matrix stays undefined until written.
// cmd is not ready from a solve until its last result is taken.
module tsp_exhaustive_search #(
  parameter int MAX_CITIES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  tsp_in_if.sink                    cmd,
  tsp_out_if.source                 res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsp_pkg::ADDR_W-1:0] paddr,
  input  logic [tsp_pkg::DATA_W-1:0] pwdata,
  output logic [tsp_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import tsp_pkg::*;

  // IW indexes a city inside the table, NW holds a count up to MAX_CITIES.
  localparam int IW    = $clog2(MAX_CITIES);
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  state_t state, state_next;

  logic [CNT_W-1:0]  city_count;
  logic [NW-1:0]     n;        // clamped city count of the running solve
  logic [IW-1:0]     depth;    // tour position being filled
  logic [NW-1:0]     cand;     // candidate city for that position
  logic [NW-1:0]     k;        // result index while emitting
  logic [MAX_CITIES-1:0] visited;
  logic [IW-1:0]     route      [MAX_CITIES];
  logic [LEN_W-1:0]  plen       [MAX_CITIES];
  logic [IW-1:0]     best_route [MAX_CITIES];
  logic [LEN_W-1:0]  best_len;

  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic [DIST_W-1:0] rdata;
  logic [AW-1:0]     rd_addr;

  logic [IW-1:0]     depth_m1;
  logic [IW-1:0]     prev;
  logic              scan_end;
  logic              last_pos;
  logic [LEN_W-1:0]  sum;
  logic              cmd_fire;
  logic              res_fire;
  logic [NW-1:0]     n_clamped;

  // --------------------------------------------------------------------------
  // Configuration port. Writes and reads decode paddr[2] as register index.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CITY_COUNT) ? DATA_W'(city_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CITY_COUNT) begin
      city_count <= pwdata[CNT_W-1:0];
    end
  end

  // Counts below two run as two, counts above the table size as the table size.
  always_comb begin
    if (city_count < CNT_W'(2)) begin
      n_clamped = NW'(2);
    end else if (int'(city_count) > MAX_CITIES) begin
      n_clamped = NW'(MAX_CITIES);
    end else begin
      n_clamped = NW'(city_count);
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes and shared datapath terms.
  // --------------------------------------------------------------------------
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res_fire  = res.valid && res.ready;

  assign depth_m1 = depth - IW'(1);
  assign prev     = route[depth_m1];
  assign scan_end = (cand >= n);
  assign last_pos = (NW'(depth) == n - NW'(1));

  // One adder serves both the extension of a partial tour and the closing
  // edge back to city 0; the memory word read in the previous cycle feeds it.
  always_comb begin
    if (state == ST_CLOSE) begin
      sum = plen[depth] + LEN_W'(rdata);
    end else begin
      sum = plen[depth_m1] + LEN_W'(rdata);
    end
  end

  // Read address: the edge into the candidate while scanning, the edge home
  // once the last position has been placed.
  always_comb begin
    if (state == ST_ADD) begin
      rd_addr = {cand[IW-1:0], IW'(0)};
    end else begin
      rd_addr = {prev, cand[IW-1:0]};
    end
  end

  // --------------------------------------------------------------------------
  // Distance memory: one write port from the command channel, one read port.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.command == CMD_WRITE &&
        int'(cmd.from_city) < MAX_CITIES && int'(cmd.to_city) < MAX_CITIES) begin
      dist_mem[{cmd.from_city[IW-1:0], cmd.to_city[IW-1:0]}] <= cmd.distance;
    end
    rdata <= dist_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_fire && cmd.command == CMD_SOLVE) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (depth == IW'(1)) begin
            state_next = ST_EMIT;
          end
        end else if (!visited[cand[IW-1:0]]) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = last_pos ? ST_CLOSE : ST_SCAN;
      end
      ST_CLOSE: begin
        state_next = ST_SCAN;
      end
      ST_EMIT: begin
        if (res_fire && k == n) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Search stack and best tour.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_fire && cmd.command == CMD_SOLVE) begin
          n        <= n_clamped;
          depth    <= IW'(1);
          cand     <= NW'(1);
          visited  <= MAX_CITIES'(1);
          route[0] <= '0;
          plen[0]  <= '0;
          best_len <= '1;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (depth == IW'(1)) begin
            k <= '0;
          end else begin
            // Position exhausted: step back and try the next city there.
            depth          <= depth_m1;
            cand           <= NW'(prev) + NW'(1);
            visited[prev]  <= 1'b0;
          end
        end else if (visited[cand[IW-1:0]]) begin
          cand <= cand + NW'(1);
        end
      end
      ST_ADD: begin
        route[depth]          <= cand[IW-1:0];
        plen[depth]           <= sum;
        visited[cand[IW-1:0]] <= 1'b1;
        if (!last_pos) begin
          depth <= depth + IW'(1);
          cand  <= NW'(1);
        end
      end
      ST_CLOSE: begin
        // Strictly smaller only, so the earliest minimum is kept.
        if (sum < best_len) begin
          best_len   <= sum;
          best_route <= route;
        end
        visited[cand[IW-1:0]] <= 1'b0;
        cand                  <= cand + NW'(1);
      end
      ST_EMIT: begin
        if (res_fire) begin
          k <= k + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result channel: the tour is closed by repeating city 0 at step n.
  // --------------------------------------------------------------------------
  assign res.valid       = (state == ST_EMIT);
  assign res.step        = STEP_W'(k);
  assign res.city        = (k < n) ? CITY_W'(best_route[k[IW-1:0]]) : '0;
  assign res.tour_length = best_len;
  assign res.last        = (k == n);

endmodule

[design/tsp_checker.sv]
// ----------------------------------------------------------------------------
// tsp_checker: port-level checks for the tour search
// Watches the command and result channels and binds to the top level.
// ----------------------------------------------------------------------------
module tsp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       cmd_command,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [tsp_pkg::STEP_W-1:0] res_step,
  input logic [tsp_pkg::CITY_W-1:0] res_city,
  input logic                       res_last
);
  import tsp_pkg::*;

  // A stalled result stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Commands are never taken while results are being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd_ready && res_valid))
    else $error("command ready during result delivery");

  // A solve closes the command channel.
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_command == CMD_SOLVE |=> !cmd_ready)
    else $error("command taken during a solve");

  // After the final city the block returns to accepting commands.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_last |=> cmd_ready && !res_valid)
    else $error("block not idle after last result");

  // Every tour starts at city 0.
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_step == '0 |-> res_city == '0)
    else $error("tour does not start at city 0");

endmodule

bind tsp_exhaustive_search tsp_checker u_tsp_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_command (cmd.command),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_step    (res.step),
  .res_city    (res.city),
  .res_last    (res.last)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the exhaustive tour search
// Loads distance matrices over the command channel, sweeps city_count over
// the APB port and checks every emitted tour city against a local search.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import tsp_pkg::*;

  localparam int MAXC       = 8;
  localparam int WD_LIMIT   = 500000;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 16;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [CITY_W-1:0] city;
    logic [LEN_W-1:0]  tour_length;
    logic              last;
  } tour_point_t;

  // Scoreboard: keeps its own matrix and city_count, runs the same
  // depth-first search on each solve and queues the tour it expects.
  class tour_scoreboard;
    logic [DIST_W-1:0] dist_mat [MAXC][MAXC];
    bit                written  [MAXC][MAXC];
    int                count_reg;
    tour_point_t       pending_points [$];
    int                errors;
    int                checked;
    int                solves;
    int                writes;
    int                route [MAXC+1];
    int                best_route [MAXC+1];
    int unsigned       best_len;
    bit                seen [MAXC];

    function new();
      count_reg = int'(CITY_COUNT_RESET);
      errors = 0;
      checked = 0;
      solves = 0;
      writes = 0;
      foreach (written[i, j]) written[i][j] = 0;
    endfunction

    function int eff_count();
      if (count_reg < 2) return 2;
      if (count_reg > MAXC) return MAXC;
      return count_reg;
    endfunction

    function bit covered(int n);
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (i != j && !written[i][j]) return 0;
      return 1;
    endfunction

    function void walk(int depth, int n, int prev, int unsigned len);
      int unsigned total;
      if (depth == n) begin
        total = len + dist_mat[prev][0];
        if (total < best_len) begin
          best_len = total;
          for (int k = 0; k < n; k++) best_route[k] = route[k];
          best_route[n] = 0;
        end
        return;
      end
      for (int c = 1; c < n; c++) begin
        if (!seen[c]) begin
          seen[c] = 1;
          route[depth] = c;
          walk(depth + 1, n, c, len + dist_mat[prev][c]);
          seen[c] = 0;
        end
      end
    endfunction

    function void note_input(command_t op, logic [CITY_W-1:0] f, logic [CITY_W-1:0] t,
                             logic [DIST_W-1:0] d);
      int n;
      tour_point_t p;
      if (op == CMD_WRITE) begin
        writes++;
        // Writes outside the table are dropped by the block.
        if (f < MAXC && t < MAXC) begin
          dist_mat[f][t] = d;
          written[f][t] = 1;
        end
        return;
      end
      solves++;
      n = eff_count();
      foreach (seen[i]) seen[i] = 0;
      seen[0] = 1;
      route[0] = 0;
      best_len = (1 << LEN_W) - 1;
      walk(1, n, 0, 0);
      for (int k = 0; k <= n; k++) begin
        p.step = STEP_W'(k);
        p.city = CITY_W'(best_route[k]);
        p.tour_length = LEN_W'(best_len);
        p.last = (k == n);
        pending_points = {pending_points, p};
      end
    endfunction

    function void check_result(tour_point_t got);
      tour_point_t exp_p;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result step=%0d city=%0d len=%0d last=%0b",
                 $time, got.step, got.city, got.tour_length, got.last);
        errors++;
        return;
      end
      exp_p = pending_points.pop_front();
      checked++;
      if (got.step !== exp_p.step) begin
        $display("%0t: step mismatch expected %0d actual %0d", $time, exp_p.step, got.step);
        errors++;
      end
      if (got.city !== exp_p.city) begin
        $display("%0t: city mismatch at step %0d expected %0d actual %0d",
                 $time, exp_p.step, exp_p.city, got.city);
        errors++;
      end
      if (got.tour_length !== exp_p.tour_length) begin
        $display("%0t: tour_length mismatch expected %0d actual %0d",
                 $time, exp_p.tour_length, got.tour_length);
        errors++;
      end
      if (got.last !== exp_p.last) begin
        $display("%0t: last mismatch at step %0d expected %0b actual %0b",
                 $time, exp_p.step, exp_p.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tsp_in_if  cmd_if ();
  tsp_out_if res_if ();

  tsp_exhaustive_search #(.MAX_CITIES(MAXC)) u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if.sink),
    .res     (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tour_scoreboard sb;
  bit quiet;        // set for the final stretch: no idling on either side
  int hold_req;     // bumped by the stimulus to ask for one long receiver hold
  int hold_done;
  int wd_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result side. The receiver alternates random ready bursts with stalls,
  // and serves a long hold when the stimulus asks for one.
  // Every transfer is checked right here, against the oldest expectation.
  int rdy_left;
  int hold_left;
  always @(posedge clk) begin
    tour_point_t got;
    if (rst) begin
      res_if.ready <= 1'b0;
      rdy_left = 0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.step = res_if.step;
        got.city = res_if.city;
        got.tour_length = res_if.tour_length;
        got.last = res_if.last;
        sb.check_result(got);
      end
      if (hold_left == 0 && hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (quiet) begin
        res_if.ready <= 1'b1;
      end else begin
        if (rdy_left == 0) begin
          rdy_left = $urandom_range(1, 10);
          res_if.ready <= ($urandom_range(0, 9) < 6);
        end
        rdy_left--;
      end
    end
  end

  // Watchdog: a solve at the largest size makes no transfer at all until its
  // first result, so the limit sits above the longest such search.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      wd_count <= 0;
    end else begin
      wd_count <= wd_count + 1;
      if (wd_count >= WD_LIMIT) begin
        $display("%0t: watchdog expired with no transfer", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One command transfer. An idle burst lowers valid first; otherwise valid
  // stays high straight from the previous transfer.
  task automatic send_cmd(command_t op, logic [CITY_W-1:0] f, logic [CITY_W-1:0] t,
                          logic [DIST_W-1:0] d);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= op;
    cmd_if.from_city <= f;
    cmd_if.to_city   <= t;
    cmd_if.distance  <= d;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_input(op, f, t, d);
  endtask

  // Sender pause: wait for every expected result, then let the block settle.
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CITY_COUNT, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.count_reg = int'(value[CNT_W-1:0]);
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return DIST_W'($urandom_range(0, 3));   // small values force ties
      default: return DIST_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Writes every missing off-diagonal entry among the cities in use, so a
  // solve never touches an entry that was never loaded.
  task automatic fill_matrix(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i != j && !sb.written[i][j])
          send_cmd(CMD_WRITE, CITY_W'(i), CITY_W'(j), pick_distance());
  endtask

  int count_plan [] = '{0, 1, 3, 4, 15, 5, 6, 2, 7, 12, 4, 3, 8, 2, 5};
  int n_eff;

  initial begin
    sb = new();
    quiet = 0;
    hold_req = 0;
    hold_done = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.command <= CMD_WRITE;
    cmd_if.from_city <= '0;
    cmd_if.to_city <= '0;
    cmd_if.distance <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: two cities at the reset count, extreme distances, writes that
    // fall outside the table, then a repeated solve over a changed matrix.
    send_cmd(CMD_WRITE, 0, 1, '0);
    send_cmd(CMD_WRITE, 1, 0, '1);
    send_cmd(CMD_WRITE, 4'hF, 4'hF, '1);
    send_cmd(CMD_WRITE, 4'h8, 4'h0, 16'h5555);
    send_cmd(CMD_WRITE, 4'h0, 4'h9, 16'hAAAA);
    send_cmd(CMD_WRITE, 4'h7, 4'hE, 16'h1234);
    send_cmd(CMD_SOLVE, 0, 0, 0);
    send_cmd(CMD_SOLVE, 0, 0, 0);
    send_cmd(CMD_WRITE, 1, 0, 16'h0001);
    send_cmd(CMD_WRITE, 0, 1, '1);
    send_cmd(CMD_SOLVE, 4'hF, 4'hF, '1);
    drain();

    // Random phases, one city_count setting each; every register change
    // happens with nothing in flight.
    foreach (count_plan[p]) begin
      if (p >= count_plan.size() - 3) quiet = 1;
      apb_write(count_plan[p]);
      n_eff = sb.eff_count();
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0)
          send_cmd(CMD_WRITE, CITY_W'($urandom_range(8, 15)),
                   CITY_W'($urandom_range(0, 15)), DIST_W'($urandom_range(0, 65535)));
        else
          send_cmd(CMD_WRITE, CITY_W'($urandom_range(0, MAXC - 1)),
                   CITY_W'($urandom_range(0, MAXC - 1)), pick_distance());
      end
      fill_matrix(n_eff);
      // On one small setting the receiver holds off for a long stretch while
      // more commands are offered, so the input stalls behind the results.
      if (p == 2) hold_req++;
      send_cmd(CMD_SOLVE, CITY_W'($urandom_range(0, 15)), CITY_W'($urandom_range(0, 15)),
               DIST_W'($urandom_range(0, 65535)));
      if (n_eff <= 5) begin
        send_cmd(CMD_WRITE, CITY_W'($urandom_range(0, n_eff - 1)),
                 CITY_W'($urandom_range(0, n_eff - 1)), pick_distance());
        send_cmd(CMD_SOLVE, 0, 0, 0);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d distance writes and %0d solves over %0d city_count settings;",
             sb.writes, sb.solves, count_plan.size() + 1);
    $display("checked %0d tour cities, %0d still expected.", sb.checked,
             sb.pending_points.size());
    if (sb.errors == 0 && sb.pending_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tsp_pkg.sv
design/tsp_in_if.sv
design/tsp_out_if.sv
design/tsp_exhaustive_search.sv
design/tsp_checker.sv
dv/tb_top.sv
